### rtl/dss_pkg.sv
`default_nettype none
package dss_pkg;
  localparam int TRACKS = 8;
  localparam int STEPS = 16;
  localparam int TW = $clog2(TRACKS);
  localparam int SW = $clog2(STEPS);
  localparam int DEPTH = TRACKS * STEPS;
  localparam int AW = $clog2(DEPTH);
  localparam logic [6:0] VEL_DEFAULT = 7'd100;
  localparam logic [19:0] BASE_MIN = 20'd50000;
  localparam logic [19:0] BASE_MAX = 20'd750000;
  localparam logic [7:0] SWING_MAX = 8'd192;
  localparam logic [2:0] PULSES_PER_STEP = 3'd6;

  localparam logic [3:0] OP_SET = 4'd0;
  localparam logic [3:0] OP_TOGGLE = 4'd1;
  localparam logic [3:0] OP_CLEAR = 4'd2;
  localparam logic [3:0] OP_READ = 4'd3;
  localparam logic [3:0] OP_START = 4'd4;
  localparam logic [3:0] OP_STOP = 4'd5;
  localparam logic [3:0] OP_TICK = 4'd6;
  localparam logic [3:0] OP_PULSE = 4'd7;
  localparam logic [3:0] OP_MSTART = 4'd8;
  localparam logic [3:0] OP_CONT = 4'd9;
  localparam logic [3:0] OP_MSTOP = 4'd10;

  localparam logic [1:0] KIND_NOTE = 2'd0;
  localparam logic [1:0] KIND_ADV = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_SWING = 2'd1;
  localparam logic [1:0] REG_EXT = 2'd2;
  localparam logic [1:0] REG_MUTE = 2'd3;

  typedef struct packed {
    logic [3:0] operation;
    logic [2:0] track;
    logic [3:0] step;
    logic       on_flag;
    logic [7:0] velocity;
    logic       clear_all;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] track_res;
    logic [3:0] step_res;
    logic       on_flag_res;
    logic [6:0] velocity_res;
    logic       last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic          latch_in;   // capture accepted request
    logic          mem_rd;     // read store at rd address
    logic          rd_fire;    // 1: fire address, 0: request address
    logic [TW-1:0] trk;        // track counter
    logic          mem_wr;
    logic          wr_edit;    // 1: set from request or toggle from read data, 0: clear value
    logic [SW-1:0] clr_step;
    logic          apply_ctl;  // update timing state for latched request
    logic          mul_go;     // start interval product
    logic          load_wait;  // load wait_count from product
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [3:0] op;
    logic       all;
    logic [2:0] trk_in;
    logic       fire;       // latched request fires a step
    logic       tick_fire;  // fire came from a tick
    logic       note_hit;   // read data gives an unmuted note on current track
  } sts_t;
endpackage
`default_nettype wire

### rtl/dss_ram.sv
`default_nettype none
module dss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/dss_datapath.sv
`default_nettype none
module dss_datapath (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire dss_pkg::in_item_t in_item,
  input  wire logic            cfg_we,
  input  wire logic [1:0]      cfg_idx,
  input  wire logic [19:0]     cfg_val,
  input  wire dss_pkg::cmd_t   cmd,
  output dss_pkg::sts_t        sts,
  output dss_pkg::out_item_t   res_note,
  output dss_pkg::out_item_t   res_adv,
  output dss_pkg::out_item_t   res_read
);
  import dss_pkg::*;

  in_item_t   req_r;
  logic [19:0] base_r;
  logic [7:0]  swing_r, mute_r;
  logic        ext_r, running_r;
  logic [SW-1:0] next_step_r, fire_step_r;
  logic [20:0] wait_r;
  logic [2:0]  pulse_r;
  logic [28:0] prod_r;
  logic        ok;
  logic [7:0]  rdata, wdata;
  logic [AW-1:0] raddr, waddr;
  logic [19:0] base_sat;
  logic [7:0]  sw_sat;
  logic [8:0]  factor;
  logic [6:0]  vel_sat;

  assign ok = ({1'b0, req_r.track} < 4'(TRACKS)) && ({1'b0, req_r.step} < 5'(STEPS));
  assign raddr = cmd.rd_fire ? {cmd.trk, fire_step_r} : {req_r.track[TW-1:0], req_r.step[SW-1:0]};
  assign vel_sat = (req_r.velocity > 8'd127) ? 7'd127 : req_r.velocity[6:0];

  always_comb begin
    if (!cmd.wr_edit) begin
      waddr = {cmd.trk, cmd.clr_step};
      wdata = {1'b0, VEL_DEFAULT};
    end else begin
      waddr = {req_r.track[TW-1:0], req_r.step[SW-1:0]};
      if (req_r.operation == OP_SET) wdata = {req_r.on_flag, vel_sat};
      else wdata = rdata ^ 8'h80;
    end
  end

  dss_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(cmd.mem_wr), .waddr(waddr), .wdata(wdata),
    .re(cmd.mem_rd), .raddr(raddr), .rdata(rdata)
  );

  assign base_sat = (base_r < BASE_MIN) ? BASE_MIN : (base_r > BASE_MAX) ? BASE_MAX : base_r;
  assign sw_sat = (swing_r > SWING_MAX) ? SWING_MAX : swing_r;
  assign factor = next_step_r[0] ? (9'd256 - {1'b0, sw_sat}) : (9'd256 + {1'b0, sw_sat});

  assign sts.op = req_r.operation;
  assign sts.all = req_r.clear_all;
  assign sts.trk_in = req_r.track;
  assign sts.tick_fire = (req_r.operation == OP_TICK) && !ext_r && running_r && (wait_r == '0);
  assign sts.fire = sts.tick_fire ||
    ((req_r.operation == OP_PULSE) && ext_r && running_r && (pulse_r == '0));
  assign sts.note_hit = rdata[7] && !mute_r[cmd.trk];

  always_ff @(posedge clk) begin
    if (cmd.latch_in) req_r <= in_item;
    if (cmd.mul_go) prod_r <= base_sat * factor;
    if (!rst_n) begin
      base_r <= 20'd125000; swing_r <= '0; ext_r <= 1'b0; mute_r <= '0;
      running_r <= 1'b0; next_step_r <= '0; wait_r <= '0; pulse_r <= '0;
      fire_step_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_BASE: base_r <= cfg_val;
          REG_SWING: swing_r <= cfg_val[7:0];
          REG_EXT: if (cfg_val[0] != ext_r) begin
            running_r <= 1'b0; pulse_r <= '0; ext_r <= cfg_val[0];
          end
          REG_MUTE: mute_r <= cfg_val[7:0];
          default: ;
        endcase
      end
      if (cmd.apply_ctl) begin
        if (sts.fire) begin
          fire_step_r <= next_step_r;
          next_step_r <= next_step_r + 1'b1;
        end
        case (req_r.operation)
          OP_START: begin running_r <= 1'b1; next_step_r <= '0; wait_r <= '0; end
          OP_STOP: running_r <= 1'b0;
          OP_TICK: if (!ext_r && running_r && wait_r != '0) wait_r <= wait_r - 1'b1;
          OP_PULSE: if (ext_r && running_r)
            pulse_r <= (pulse_r + 3'd1 >= PULSES_PER_STEP) ? 3'd0 : pulse_r + 3'd1;
          OP_MSTART: if (ext_r) begin running_r <= 1'b1; next_step_r <= '0; pulse_r <= '0; end
          OP_CONT: if (ext_r) running_r <= 1'b1;
          OP_MSTOP: if (ext_r) running_r <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.load_wait) wait_r <= prod_r[28:8] - 21'd1;
    end
  end

  always_comb begin
    res_note = '0;
    res_note.kind = KIND_NOTE;
    res_note.track_res = 3'(cmd.trk);
    res_note.step_res = 4'(fire_step_r);
    res_note.on_flag_res = 1'b1;
    res_note.velocity_res = rdata[6:0];
    res_adv = '0;
    res_adv.kind = KIND_ADV;
    res_adv.step_res = 4'(fire_step_r);
    res_adv.last = 1'b1;
    res_read = '0;
    res_read.kind = KIND_READ;
    res_read.track_res = req_r.track;
    res_read.step_res = req_r.step;
    res_read.on_flag_res = ok & rdata[7];
    res_read.velocity_res = ok ? rdata[6:0] : 7'd0;
    res_read.last = 1'b1;
  end
endmodule
`default_nettype wire

### rtl/dss_ctrl.sv
`default_nettype none
module dss_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  output logic                   in_rdy,
  input  wire logic              out_free,
  output logic                   out_load,
  output logic [1:0]             out_sel,  // 0 note, 1 advance, 2 read
  output logic                   note_last,
  input  wire dss_pkg::sts_t     sts,
  output dss_pkg::cmd_t          cmd
);
  import dss_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DEC   = 9'b000000010,
    S_EDRD  = 9'b000000100,
    S_EDWR  = 9'b000001000,
    S_CLR   = 9'b000010000,
    S_RDWT  = 9'b000100000,
    S_FRD   = 9'b001000000,
    S_FCHK  = 9'b010000000,
    S_ADV   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [TW-1:0] trk_r, trk_nxt;
  logic [SW-1:0] stp_r, stp_nxt;
  logic tick_r, tick_nxt;
  logic init_r, init_nxt;
  logic [1:0] mcnt_r, mcnt_nxt;
  logic last_trk;
  logic ok;

  assign last_trk = (trk_r == TW'(TRACKS - 1));
  assign ok = ({1'b0, sts.trk_in} < 4'(TRACKS));
  assign in_rdy = (state_r == S_IDLE) && (mcnt_r == '0);

  always_comb begin
    state_nxt = state_r; trk_nxt = trk_r; stp_nxt = stp_r; tick_nxt = tick_r;
    init_nxt = init_r;
    mcnt_nxt = (mcnt_r != '0) ? mcnt_r - 2'd1 : mcnt_r;
    cmd = '0;
    cmd.trk = trk_r;
    cmd.clr_step = stp_r;
    cmd.wr_edit = 1'b1;
    out_load = 1'b0; out_sel = 2'd0; note_last = 1'b0;
    if (mcnt_r == 2'd1) cmd.load_wait = 1'b1;
    case (state_r)
      S_IDLE: begin
        cmd.latch_in = in_fire;
        if (in_fire) state_nxt = S_DEC;
      end
      S_DEC: begin
        case (sts.op)
          OP_SET, OP_TOGGLE: begin cmd.mem_rd = 1'b1; state_nxt = S_EDRD; end
          OP_READ: begin cmd.mem_rd = 1'b1; state_nxt = S_RDWT; end
          OP_CLEAR: begin
            trk_nxt = sts.all ? '0 : sts.trk_in[TW-1:0]; stp_nxt = '0;
            state_nxt = (sts.all || ok) ? S_CLR : S_IDLE;
          end
          default: begin
            cmd.apply_ctl = 1'b1;
            tick_nxt = sts.tick_fire;
            trk_nxt = '0;
            state_nxt = sts.fire ? S_FRD : S_IDLE;
          end
        endcase
      end
      S_EDRD: state_nxt = S_EDWR;
      S_EDWR: begin
        cmd.mem_wr = ({1'b0, sts.trk_in} < 4'(TRACKS));
        state_nxt = S_IDLE;
      end
      S_CLR: begin
        cmd.mem_wr = 1'b1; cmd.wr_edit = 1'b0;
        stp_nxt = stp_r + 1'b1;
        if (stp_r == SW'(STEPS - 1)) begin
          if ((sts.all || init_r) && !last_trk) trk_nxt = trk_r + 1'b1;
          else begin
            state_nxt = S_IDLE;
            init_nxt = 1'b0;
          end
        end
      end
      S_RDWT: if (out_free) begin
        out_load = 1'b1; out_sel = 2'd2; state_nxt = S_IDLE;
      end
      S_FRD: begin
        cmd.mem_rd = 1'b1; cmd.rd_fire = 1'b1; state_nxt = S_FCHK;
      end
      S_FCHK: begin
        if (!sts.note_hit) begin
          if (last_trk) state_nxt = S_ADV;
          else begin trk_nxt = trk_r + 1'b1; state_nxt = S_FRD; end
        end else if (out_free) begin
          out_load = 1'b1; out_sel = 2'd0;
          if (last_trk) state_nxt = S_ADV;
          else begin trk_nxt = trk_r + 1'b1; state_nxt = S_FRD; end
        end
      end
      S_ADV: if (out_free) begin
        out_load = 1'b1; out_sel = 2'd1; state_nxt = S_IDLE;
        if (tick_r) begin cmd.mul_go = 1'b1; mcnt_nxt = 2'd1; end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; trk_r <= '0; stp_r <= '0; tick_r <= 1'b0; mcnt_r <= '0;
      init_r <= 1'b1;
    end else begin
      state_r <= state_nxt; trk_r <= trk_nxt; stp_r <= stp_nxt;
      tick_r <= tick_nxt; mcnt_r <= mcnt_nxt; init_r <= init_nxt;
    end
  end
endmodule
`default_nettype wire

### rtl/drum_step_sequencer_swing.sv
`default_nettype none
// Eight-track, sixteen-step drum sequencer. After reset the pattern RAM is
// cleared, all 128 entries, before the first request is taken. An edit reads
// its entry and then writes it, a read waits for a free output slot, a clear
// writes every step of one track or of all tracks, and a fired step walks the
// pattern RAM one track per visit, emits a note per unmuted hit, then an advance.
// After a fired tick step the next request also waits while the wait is loaded.
// The step-wait product (base x swing factor) is computed once per fired tick step.
module drum_step_sequencer_swing (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,  // operation, track, step, on_flag, velocity, clear_all
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [19:0] cfg_data,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata, // kind, track_res, step_res, on_flag_res, velocity_res
  output logic             out_tlast
);
  import dss_pkg::*;

  in_item_t in_item;
  cmd_t cmd;
  sts_t sts;
  out_item_t res_note, res_adv, res_read, sel;
  logic out_load, note_last, out_free, in_fire;
  logic [1:0] out_sel;
  logic [16:0] odata_r;
  logic olast_r, ovalid_r;

  assign in_item.operation = in_tdata[3:0];
  assign in_item.track = in_tdata[6:4];
  assign in_item.step = in_tdata[10:7];
  assign in_item.on_flag = in_tdata[11];
  assign in_item.velocity = in_tdata[19:12];
  assign in_item.clear_all = in_tdata[20];
  assign in_fire = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free = !ovalid_r || out_tready;

  dss_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item),
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_val(cfg_data),
    .cmd(cmd), .sts(sts), .res_note(res_note), .res_adv(res_adv), .res_read(res_read)
  );

  dss_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_rdy(in_tready),
    .out_free(out_free), .out_load(out_load), .out_sel(out_sel),
    .note_last(note_last), .sts(sts), .cmd(cmd)
  );

  always_comb begin
    case (out_sel)
      2'd0: sel = res_note;
      2'd1: sel = res_adv;
      default: sel = res_read;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      odata_r <= {sel.velocity_res, sel.on_flag_res, sel.step_res, sel.track_res, sel.kind};
      olast_r <= sel.last | note_last;
    end
    if (!rst_n) ovalid_r <= 1'b0;
    else if (out_load) ovalid_r <= 1'b1;
    else if (out_tready) ovalid_r <= 1'b0;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = {7'b0, odata_r};
  assign out_tlast = olast_r;
endmodule
`default_nettype wire

### rtl/dss_checker.sv
`default_nettype none
module dss_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_tvalid,
  input wire logic in_tready,
  input wire logic out_tvalid,
  input wire logic out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic out_tlast
);
  import dss_pkg::*;
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out held request changed");
  a_adv_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == KIND_ADV |-> out_tlast)
    else $error("advance not last");
  a_note_notlast: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == KIND_NOTE |-> !out_tlast)
    else $error("note marked last");
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != 2'd3)
    else $error("bad kind");
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid)
    else $error("in request dropped");
endmodule
bind drum_step_sequencer_swing dss_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);
`default_nettype wire

### tb/sv/tb_drum_step_sequencer_swing.sv
`timescale 1ns / 1ps
module tb_drum_step_sequencer_swing;
  import dss_pkg::*;

  class seq_scoreboard;
    logic [7:0]  pattern [DEPTH];
    bit          running;
    logic [3:0]  next_step;
    logic [20:0] wait_count;
    logic [2:0]  pulse_count;
    logic [19:0] base_us;
    logic [7:0]  swing;
    bit          ext_clk;
    logic [7:0]  mute;
    out_item_t   pending [$];
    int          errors;

    function new();
      for (int i = 0; i < DEPTH; i++) pattern[i] = {1'b0, VEL_DEFAULT};
      running = 0;
      next_step = 0;
      wait_count = 0;
      pulse_count = 0;
      base_us = 20'd125000;
      swing = 0;
      ext_clk = 0;
      mute = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [19:0] val);
      case (idx)
        REG_BASE: base_us = val;
        REG_SWING: swing = val[7:0];
        REG_EXT: begin
          if (val[0] != ext_clk) begin
            running = 0;
            pulse_count = 0;
            ext_clk = val[0];
          end
        end
        REG_MUTE: mute = val[7:0];
        default: ;
      endcase
    endfunction

    function logic [20:0] step_wait(logic [3:0] s);
      logic [19:0] b;
      logic [7:0]  w;
      logic [8:0]  f;
      logic [28:0] p;
      b = base_us;
      w = swing;
      if (b < BASE_MIN) b = BASE_MIN;
      if (b > BASE_MAX) b = BASE_MAX;
      if (w > SWING_MAX) w = SWING_MAX;
      f = s[0] ? 9'd256 - w : 9'd256 + w;
      p = b * f;
      return p[28:8];
    endfunction

    function void push(logic [1:0] k, logic [2:0] t, logic [3:0] s, logic o, logic [6:0] v);
      out_item_t r;
      r = '{kind: k, track_res: t, step_res: s, on_flag_res: o, velocity_res: v, last: 0};
      pending.push_back(r);
    endfunction

    function void fire_step();
      logic [7:0] c;
      for (int t = 0; t < TRACKS; t++) begin
        c = pattern[t * STEPS + next_step];
        if (!mute[t] && c[7]) push(KIND_NOTE, t[2:0], next_step, 1'b1, c[6:0]);
      end
      push(KIND_ADV, 3'd0, next_step, 1'b0, 7'd0);
      next_step = next_step + 4'd1;
    endfunction

    function void note_request(in_item_t it);
      int before_n;
      int a;
      logic [7:0] c;
      before_n = pending.size();
      a = it.track * STEPS + it.step;
      case (it.operation)
        OP_SET: pattern[a] = {it.on_flag, it.velocity > 8'd127 ? 7'd127 : it.velocity[6:0]};
        OP_TOGGLE: pattern[a][7] = ~pattern[a][7];
        OP_CLEAR: begin
          for (int t = 0; t < TRACKS; t++)
            if (it.clear_all || t == it.track)
              for (int s = 0; s < STEPS; s++) pattern[t * STEPS + s] = {1'b0, VEL_DEFAULT};
        end
        OP_READ: begin
          c = pattern[a];
          push(KIND_READ, it.track, it.step, c[7], c[6:0]);
        end
        OP_START: begin
          running = 1;
          next_step = 0;
          wait_count = 0;
        end
        OP_STOP: running = 0;
        OP_TICK: begin
          if (!ext_clk && running) begin
            if (wait_count == 0) begin
              fire_step();
              wait_count = step_wait(next_step);
            end
            if (wait_count > 0) wait_count = wait_count - 21'd1;
          end
        end
        OP_PULSE: begin
          if (ext_clk && running) begin
            if (pulse_count == 0) fire_step();
            pulse_count = (pulse_count + 3'd1 >= PULSES_PER_STEP) ? 3'd0 : pulse_count + 3'd1;
          end
        end
        OP_MSTART: begin
          if (ext_clk) begin
            running = 1;
            next_step = 0;
            pulse_count = 0;
          end
        end
        OP_CONT: if (ext_clk) running = 1;
        OP_MSTOP: if (ext_clk) running = 0;
        default: ;
      endcase
      if (pending.size() > before_n) pending[pending.size() - 1].last = 1;
    endfunction

    function void check_result(logic [23:0] d, logic lst);
      logic [23:0] w;
      out_item_t e;
      w = d;
      if (pending.size() == 0) begin
        $error("unexpected result data=%h last=%b", d, lst);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (w[1:0] != e.kind) begin
        $error("kind exp %0d got %0d", e.kind, w[1:0]); errors++;
      end
      if (w[4:2] != e.track_res) begin
        $error("track_res exp %0d got %0d", e.track_res, w[4:2]); errors++;
      end
      if (w[8:5] != e.step_res) begin
        $error("step_res exp %0d got %0d", e.step_res, w[8:5]); errors++;
      end
      if (w[9] != e.on_flag_res) begin
        $error("on_flag_res exp %0d got %0d", e.on_flag_res, w[9]); errors++;
      end
      if (w[16:10] != e.velocity_res) begin
        $error("velocity_res exp %0d got %0d", e.velocity_res, w[16:10]); errors++;
      end
      if (lst != e.last) begin
        $error("last exp %0d got %0d", e.last, lst); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [19:0] cfg_data;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;

  seq_scoreboard sb;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  logic          hold_out;
  longint        cycles;
  bit            in_ext;

  drum_step_sequencer_swing u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  initial clk = 0;
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 600000) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    out_tready <= !hold_out && ($urandom_range(99) >= recv_idle_pct);
  end

  function logic [23:0] pack(in_item_t it);
    return {3'b0, it.clear_all, it.velocity, it.on_flag, it.step, it.track, it.operation};
  endfunction

  function in_item_t mk(logic [3:0] op, logic [2:0] t, logic [3:0] s, logic o,
                        logic [7:0] v, logic a);
    in_item_t it;
    it = '{operation: op, track: t, step: s, on_flag: o, velocity: v, clear_all: a};
    return it;
  endfunction

  task automatic send(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= pack(it);
    do @(posedge clk); while (!in_tready);
    sb.note_request(it);
  endtask

  task automatic settle();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [19:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  function in_item_t pack_rand();
    logic [23:0] w;
    w = 24'($urandom);
    return mk(w[3:0], w[6:4], w[10:7], w[11], w[19:12], w[20]);
  endfunction

  function in_item_t rand_item();
    in_item_t it;
    int r;
    it = pack_rand();
    r = $urandom_range(99);
    if (r < 15) it.operation = OP_SET;
    else if (r < 22) it.operation = OP_TOGGLE;
    else if (r < 25) it.operation = OP_CLEAR;
    else if (r < 35) it.operation = OP_READ;
    else if (r < 70) it.operation = in_ext ? OP_PULSE : OP_TICK;
    else if (r < 78) it.operation = in_ext ? OP_MSTART : OP_START;
    else if (r < 82) it.operation = OP_CONT;
    else if (r < 85) it.operation = OP_MSTOP;
    else if (r < 88) it.operation = OP_STOP;
    else if (r < 93) it.operation = in_ext ? OP_TICK : OP_PULSE;
    else if (r < 96) it.operation = OP_START;
    else it.operation = 4'($urandom_range(15, 11));
    if (it.operation == OP_CLEAR) it.clear_all = ($urandom_range(3) == 0);
    return it;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) send(rand_item());
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    out_tready = 0;
    hold_out = 0;
    in_ext = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send(mk(OP_READ, 3'd3, 4'd5, 0, 0, 0));
    send(mk(OP_SET, 3'd0, 4'd0, 1, 8'd255, 0));
    send(mk(OP_SET, 3'd7, 4'd15, 1, 8'd0, 0));
    send(mk(OP_SET, 3'd7, 4'd0, 1, 8'd127, 0));
    send(mk(OP_SET, 3'd4, 4'd0, 0, 8'd128, 1));
    send(mk(OP_TOGGLE, 3'd4, 4'd0, 0, 0, 0));
    send(mk(OP_TOGGLE, 3'd7, 4'd15, 0, 0, 0));
    send(mk(OP_READ, 3'd0, 4'd0, 0, 0, 0));
    send(mk(OP_READ, 3'd7, 4'd15, 0, 0, 0));
    send(mk(OP_TICK, 3'd0, 4'd0, 0, 0, 0));
    send(mk(OP_START, 3'd0, 4'd0, 0, 0, 0));
    send(mk(OP_TICK, 3'd0, 4'd0, 0, 0, 0));
    send(mk(OP_TICK, 3'd0, 4'd0, 0, 0, 0));
    send(mk(OP_PULSE, 3'd0, 4'd0, 0, 0, 0));
    send(mk(OP_MSTART, 3'd0, 4'd0, 0, 0, 0));
    send(mk(OP_CONT, 3'd0, 4'd0, 0, 0, 0));
    send(mk(OP_MSTOP, 3'd0, 4'd0, 0, 0, 0));
    send(mk(OP_STOP, 3'd0, 4'd0, 0, 0, 0));
    send(mk(OP_TICK, 3'd0, 4'd0, 0, 0, 0));
    send(mk(4'd15, 3'd7, 4'd15, 1, 8'hff, 1));
    send(mk(OP_CLEAR, 3'd7, 4'd3, 0, 0, 0));
    send(mk(OP_READ, 3'd7, 4'd0, 0, 0, 0));
    send(mk(OP_CLEAR, 3'd2, 4'd0, 0, 0, 1));
    send(mk(OP_READ, 3'd0, 4'd0, 0, 0, 0));
    settle();

    write_cfg(REG_BASE, 20'd50000);
    write_cfg(REG_SWING, 20'd192);
    write_cfg(REG_MUTE, 20'hA5);
    write_cfg(REG_EXT, 20'd1);
    in_ext = 1;
    send_idle_pct = 21;
    recv_idle_pct = 69;
    for (int t = 0; t < TRACKS; t++) send(mk(OP_SET, t[2:0], 4'd0, 1, 8'($urandom), 0));
    send(mk(OP_MSTART, 3'd0, 4'd0, 0, 0, 0));
    run_random(20);
    settle();

    write_cfg(REG_EXT, 20'd0);
    write_cfg(REG_BASE, 20'd0);
    write_cfg(REG_SWING, 20'd255);
    write_cfg(REG_MUTE, 20'h00);
    in_ext = 0;
    send_idle_pct = 69;
    recv_idle_pct = 21;
    fork
      begin
        hold_out <= 1;
        repeat (500) @(posedge clk);
        hold_out <= 0;
      end
      begin
        send_idle_pct = 0;
        send(mk(OP_START, 3'd0, 4'd0, 0, 0, 0));
        for (int i = 0; i < 12; i++) begin
          send(mk(OP_TICK, 3'd0, 4'd0, 0, 0, 0));
          send(mk(OP_START, 3'd0, 4'd0, 0, 0, 0));
        end
        send_idle_pct = 69;
        run_random(15);
      end
    join
    settle();

    write_cfg(REG_BASE, 20'hFFFFF);
    write_cfg(REG_SWING, 20'd0);
    write_cfg(REG_MUTE, 20'hFF);
    write_cfg(REG_EXT, 20'd1);
    write_cfg(REG_EXT, 20'd1);
    in_ext = 1;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send(mk(OP_MSTART, 3'd0, 4'd0, 0, 0, 0));
    run_random(5);
    settle();
    write_cfg(REG_MUTE, 20'h00);
    write_cfg(REG_BASE, 20'd750000);
    send(mk(OP_MSTART, 3'd0, 4'd0, 0, 0, 0));
    run_random(10);
    settle();

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

### sim.f
rtl/dss_pkg.sv
rtl/dss_ram.sv
rtl/dss_datapath.sv
rtl/dss_ctrl.sv
rtl/drum_step_sequencer_swing.sv
rtl/dss_checker.sv
tb/sv/tb_drum_step_sequencer_swing.sv
